### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the ARP cache block.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

`endif

### rtl/core/arpc_pkg.sv
// Shared constants and types of the ARP cache and responder.
// No dependencies; used by every module of the block.
package arpc_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_MY_IP = PADDR_W'(0);

	localparam logic [1:0] MODE_RX      = 2'd0;
	localparam logic [1:0] MODE_LOOKUP  = 2'd1;
	localparam logic [1:0] MODE_REQUEST = 2'd2;

	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [47:0] BCAST_MAC  = {6{8'hFF}};

	// Control from the sequencer to the table.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic             wr_new;
		logic [IDX_W-1:0] wr_addr;
	} tbl_req_t;

endpackage

### rtl/core/arpc_table.sv
// Entry table of the ARP cache: IP and MAC memories with one read and one write port,
// plus a valid flag per entry. Depends on arpc_pkg.
module arpc_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  arpc_pkg::tbl_req_t              req,
	input  logic [31:0]                     wr_ip,
	input  logic [47:0]                     wr_mac,
	output logic                            rd_valid,
	output logic [31:0]                     rd_ip,
	output logic [47:0]                     rd_mac
);

	logic [31:0] ip_mem  [arpc_pkg::TABLE_ENTRIES];
	logic [47:0] mac_mem [arpc_pkg::TABLE_ENTRIES];
	logic [arpc_pkg::TABLE_ENTRIES-1:0] valid_q;
	logic        rd_valid_q;
	logic [31:0] rd_ip_q;
	logic [47:0] rd_mac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en && req.wr_new) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mac_mem[req.wr_addr] <= wr_mac;
			if (req.wr_new) begin
				ip_mem[req.wr_addr] <= wr_ip;
			end
		end
		if (req.rd_en) begin
			rd_ip_q  <= ip_mem[req.rd_addr];
			rd_mac_q <= mac_mem[req.rd_addr];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_ip    = rd_ip_q;
	assign rd_mac   = rd_mac_q;

endmodule

### rtl/core/arp_cache_responder_unit.sv
// Top level of the ARP cache and responder: sequencer, shared comparator, result register.
// Depends on arpc_pkg and arpc_table.
//
//  channel  | handshake                  | direction | contents
//  item     | item_valid / item_stall    | in        | mode, ip_addr, mac_addr, operation, tgt_ip
//  result   | result_valid / result_stall| out       | send_*, lookup_*, learn_dropped
//  config   | APB psel/penable/pready    | in        | my_ip at byte address 0
//
// A learn scans the whole table, then writes the matching or first free entry if there is one;
// a lookup only scans. One 32-bit comparator walks the table one entry a cycle through its
// registered read port. A broadcast request (or the unused mode) skips the scan.
// item_stall is high from acceptance until the result word is placed in the output register;
// a result left waiting under result_stall holds up only the next item's final cycle.
// Reset clears all valid flags at once; no clearing pass is needed.
module arp_cache_responder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [arpc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// item channel
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [1:0]                   mode,
	input  logic [31:0]                  ip_addr,
	input  logic [47:0]                  mac_addr,
	input  logic [15:0]                  operation,
	input  logic [31:0]                  tgt_ip,
	// result channel
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic                         send_frame,
	output logic                         send_reply,
	output logic [47:0]                  send_dst_mac,
	output logic [31:0]                  send_tgt_ip,
	output logic                         lookup_hit,
	output logic [47:0]                  lookup_mac,
	output logic                         learn_dropped
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_WRITE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic [31:0] my_ip_q;

	logic [1:0]  mode_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [15:0] op_q;
	logic [31:0] target_q;

	logic [arpc_pkg::IDX_W-1:0] idx_q;
	logic                       issuing_q;
	logic                       cmp_vld_s1;
	logic [arpc_pkg::IDX_W-1:0] cmp_idx_s1;
	logic                       found_q;
	logic [arpc_pkg::IDX_W-1:0] found_idx_q;
	logic [47:0]                found_mac_q;
	logic                       free_found_q;
	logic [arpc_pkg::IDX_W-1:0] free_idx_q;
	logic                       tgt_hit_q;

	logic                       result_valid_q;
	logic                       send_frame_q;
	logic                       send_reply_q;
	logic [47:0]                send_dst_mac_q;
	logic [31:0]                send_tgt_ip_q;
	logic                       lookup_hit_q;
	logic [47:0]                lookup_mac_q;
	logic                       learn_dropped_q;

	arpc_pkg::tbl_req_t tbl_req;
	logic               rd_valid;
	logic [31:0]        rd_ip;
	logic [47:0]        rd_mac;

	logic        item_take;
	logic        idx_last;
	logic        out_free;
	logic        scan_end;
	logic [31:0] cmp_a;
	logic [31:0] cmp_b;
	logic        cmp_eq;

	logic        nx_frame;
	logic        nx_reply;
	logic [47:0] nx_dst_mac;
	logic [31:0] nx_target_ip;
	logic        nx_hit;
	logic [47:0] nx_lookup_mac;
	logic        nx_dropped;

	// Configuration
	assign pready = 1'b1;
	assign prdata = (paddr == arpc_pkg::ADDR_MY_IP) ? my_ip_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_ip_q <= '0;
		end else if (psel && penable && pwrite && paddr == arpc_pkg::ADDR_MY_IP) begin
			my_ip_q <= pwdata;
		end
	end

	assign item_stall = (state_q != S_IDLE);
	assign item_take  = item_valid && (state_q == S_IDLE);
	assign idx_last   = (idx_q == arpc_pkg::IDX_W'(arpc_pkg::TABLE_ENTRIES - 1));
	assign out_free   = !result_valid_q || !result_stall;
	assign scan_end   = cmp_vld_s1 && !issuing_q;

	// The comparator checks the request target against my_ip in the first scan cycle,
	// while the first table read is still in flight, and table entries after that.
	assign cmp_a  = cmp_vld_s1 ? rd_ip : target_q;
	assign cmp_b  = cmp_vld_s1 ? ip_q  : my_ip_q;
	assign cmp_eq = (cmp_a == cmp_b);

	always_comb begin
		tbl_req.rd_en   = (state_q == S_SCAN) && issuing_q;
		tbl_req.rd_addr = idx_q;
		tbl_req.wr_en   = (state_q == S_WRITE) && (found_q || free_found_q);
		tbl_req.wr_new  = !found_q;
		tbl_req.wr_addr = found_q ? found_idx_q : free_idx_q;
	end

	arpc_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (tbl_req),
		.wr_ip    (ip_q),
		.wr_mac   (mac_q),
		.rd_valid (rd_valid),
		.rd_ip    (rd_ip),
		.rd_mac   (rd_mac)
	);

	// Sequencer and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issuing_q    <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			tgt_hit_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_take) begin
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						cmp_vld_s1   <= 1'b0;
						if (mode inside {arpc_pkg::MODE_RX, arpc_pkg::MODE_LOOKUP}) begin
							issuing_q <= 1'b1;
							state_q   <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					// Drops to zero by itself on the last compare, as issuing_q is low then.
					cmp_vld_s1 <= issuing_q;
					if (issuing_q && idx_last) begin
						issuing_q <= 1'b0;
					end
					if (!cmp_vld_s1) begin
						tgt_hit_q <= cmp_eq;
					end else begin
						if (rd_valid && cmp_eq && !found_q) begin
							found_q <= 1'b1;
						end
						if (!rd_valid && !free_found_q) begin
							free_found_q <= 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= (mode_q == arpc_pkg::MODE_RX) ? S_WRITE : S_DONE;
					end
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item fields, scan index and the captured indices need no reset.
	always_ff @(posedge clk) begin
		if (item_take) begin
			mode_q   <= mode;
			ip_q     <= ip_addr;
			mac_q    <= mac_addr;
			op_q     <= operation;
			target_q <= tgt_ip;
			idx_q    <= '0;
		end else if (state_q == S_SCAN && issuing_q && !idx_last) begin
			idx_q <= idx_q + arpc_pkg::IDX_W'(1);
		end
		if (state_q == S_SCAN) begin
			cmp_idx_s1 <= idx_q;
			if (cmp_vld_s1 && rd_valid && cmp_eq && !found_q) begin
				found_idx_q <= cmp_idx_s1;
				found_mac_q <= rd_mac;
			end
			if (cmp_vld_s1 && !rd_valid && !free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	// Result word
	always_comb begin
		nx_frame      = 1'b0;
		nx_reply      = 1'b0;
		nx_dst_mac    = '0;
		nx_target_ip  = '0;
		nx_hit        = 1'b0;
		nx_lookup_mac = '0;
		nx_dropped    = 1'b0;
		case (mode_q)
			arpc_pkg::MODE_RX: begin
				nx_dropped = !found_q && !free_found_q;
				if (tgt_hit_q && op_q == arpc_pkg::OP_REQUEST) begin
					nx_frame     = 1'b1;
					nx_reply     = 1'b1;
					nx_dst_mac   = mac_q;
					nx_target_ip = ip_q;
				end
			end
			arpc_pkg::MODE_LOOKUP: begin
				if (found_q) begin
					nx_hit        = 1'b1;
					nx_lookup_mac = found_mac_q;
				end
			end
			arpc_pkg::MODE_REQUEST: begin
				nx_frame     = 1'b1;
				nx_dst_mac   = arpc_pkg::BCAST_MAC;
				nx_target_ip = ip_q;
			end
			default: begin
				nx_frame = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			send_frame_q     <= nx_frame;
			send_reply_q     <= nx_reply;
			send_dst_mac_q   <= nx_dst_mac;
			send_tgt_ip_q    <= nx_target_ip;
			lookup_hit_q     <= nx_hit;
			lookup_mac_q     <= nx_lookup_mac;
			learn_dropped_q  <= nx_dropped;
		end
	end

	assign result_valid   = result_valid_q;
	assign send_frame     = send_frame_q;
	assign send_reply     = send_reply_q;
	assign send_dst_mac   = send_dst_mac_q;
	assign send_tgt_ip    = send_tgt_ip_q;
	assign lookup_hit     = lookup_hit_q;
	assign lookup_mac     = lookup_mac_q;
	assign learn_dropped  = learn_dropped_q;

endmodule

### rtl/core/arpc_checker.sv
// Port-level checks of the ARP cache and responder, bound to the top level.
// Depends on arpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arpc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_stall,
	input logic                         result_valid,
	input logic                         result_stall,
	input logic                         send_frame,
	input logic                         send_reply,
	input logic [47:0]                  send_dst_mac,
	input logic [31:0]                  send_tgt_ip,
	input logic                         lookup_hit,
	input logic [47:0]                  lookup_mac,
	input logic                         learn_dropped
);

	// An accepted word keeps the block busy for at least the following cycle.
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, item_valid && !item_stall, item_stall)

	// A waiting result word stays put.
	`ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(send_frame) && $stable(send_reply) && $stable(send_dst_mac)
		&& $stable(send_tgt_ip) && $stable(lookup_hit) && $stable(lookup_mac)
		&& $stable(learn_dropped))

	// A lookup never asks for a frame.
	`ASSERT_SAME(a_frame_or_hit, clk, arst_n, result_valid, !(send_frame && lookup_hit))

	// Requests the block sends itself always go to the broadcast address.
	`ASSERT_SAME(a_request_bcast, clk, arst_n, result_valid && send_frame && !send_reply,
		send_dst_mac == arpc_pkg::BCAST_MAC)

endmodule

bind arp_cache_responder_unit arpc_checker u_arpc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_stall     (item_stall),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.send_frame     (send_frame),
	.send_reply     (send_reply),
	.send_dst_mac   (send_dst_mac),
	.send_tgt_ip    (send_tgt_ip),
	.lookup_hit     (lookup_hit),
	.lookup_mac     (lookup_mac),
	.learn_dropped  (learn_dropped)
);
